// ===== rtl/core/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the floor/ceiling texel caster.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // register file
  localparam int unsigned RegW    = 12;
  localparam int unsigned PaddrW  = 3;
  localparam logic        RegHeight = 1'b0;
  localparam logic        RegWidth  = 1'b1;

  // datapath widths
  localparam int unsigned CoordW  = 24;   // Q8.16 coordinate
  localparam int unsigned DeltaW  = 28;   // signed base minus player
  localparam int unsigned AddrW   = 22;
  localparam int unsigned DivW    = 36;   // divisor width (12 x 24)
  localparam int unsigned QuoW    = 24;   // weight width, Q8.16
  localparam int unsigned TexW    = 6;

  localparam logic [CoordW-1:0] CoordMax = {CoordW{1'b1}};

  // payload that rides along with the divider
  typedef struct packed {
    logic                      ok;
    logic signed [DeltaW-1:0]  dx;
    logic signed [DeltaW-1:0]  dy;
    logic [CoordW-1:0]         px;
    logic [CoordW-1:0]         py;
    logic [AddrW-1:0]          faddr;
    logic [AddrW-1:0]          caddr;
  } tag_t;

endpackage

// ===== rtl/core/floor_ceiling_texel_caster.sv =====
// ----------------------------------------------------------------------------
// floor_ceiling_texel_caster
// One floor point, texel pair and floor/ceiling frame-buffer address pair
// per input word, fully pipelined.
// ----------------------------------------------------------------------------
// A word is taken on every clock where start is high; busy is always low.
// Each word yields one result word, shown for one cycle with done high.
// The receiver cannot stall the pipe, so results must be captured on the
// cycle done is high. The pipe has 29 register stages: setup, divisor
// multiply, the weight divider (one overflow check stage plus 24 stages
// of one quotient bit each), blend multiply and the clamp/output stage.
module floor_ceiling_texel_caster #(
  parameter int unsigned TEXTURE_SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcc_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic                          y_side,
  input  logic                          dir_positive,
  input  logic [7:0]                    cell_x,
  input  logic [7:0]                    cell_y,
  input  logic [15:0]                   wall_frac,
  input  logic [23:0]                   perp_dist,
  input  logic signed [17:0]            half_step_x,
  input  logic signed [17:0]            half_step_y,
  input  logic [23:0]                   player_x,
  input  logic [23:0]                   player_y,
  input  logic [10:0]                   row,
  input  logic [10:0]                   column,
  // result
  output logic                          done,
  output logic                          valid_res,
  output logic [23:0]                   floor_x,
  output logic [23:0]                   floor_y,
  output logic [5:0]                    tex_u,
  output logic [5:0]                    tex_v,
  output logic [21:0]                   floor_addr,
  output logic [21:0]                   ceil_addr
);
  import fcc_pkg::*;

  localparam int unsigned TsW = $clog2(TEXTURE_SIDE + 1);
  localparam logic [TsW-1:0] TexSide = TsW'(TEXTURE_SIDE);

  // configuration registers
  logic [RegW-1:0] screen_height;
  logic [RegW-1:0] screen_width;
  logic            wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= RegW'(600);
      screen_width  <= RegW'(800);
    end else if (wr_en) begin
      if (paddr[2] == RegHeight) begin
        screen_height <= pwdata[RegW-1:0];
      end else begin
        screen_width <= pwdata[RegW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegHeight) ? {20'b0, screen_height}
                                          : {20'b0, screen_width};

  // stage 1: denominator sign, base points, addresses
  logic signed [12:0]       den_c;
  logic                     ok_c;
  logic [CoordW:0]          bx_c, by_c;
  logic [CoordW:0]          cell_xs, cell_ys, frac_e, one_e;
  logic signed [DeltaW-1:0] dx_c, dy_c;
  logic [AddrW-1:0]         crow_c;

  assign den_c   = $signed({1'b0, row, 1'b0}) - $signed({1'b0, screen_height});
  assign ok_c    = !den_c[12] && (den_c != '0) && (perp_dist != '0);
  assign cell_xs = {1'b0, cell_x, 16'b0};
  assign cell_ys = {1'b0, cell_y, 16'b0};
  assign frac_e  = {9'b0, wall_frac};
  assign one_e   = dir_positive ? '0 : (CoordW+1)'(32'h10000);
  assign bx_c    = cell_xs + (y_side ? frac_e : one_e);
  assign by_c    = cell_ys + (y_side ? one_e : frac_e);
  assign dx_c    = $signed({3'b0, bx_c}) + DeltaW'(half_step_x)
                 - $signed({4'b0, player_x});
  assign dy_c    = $signed({3'b0, by_c}) + DeltaW'(half_step_y)
                 - $signed({4'b0, player_y});
  assign crow_c  = AddrW'(screen_height) - AddrW'(row) - AddrW'(1);

  logic            s1_vld;
  logic [11:0]     s1_den;
  logic [23:0]     s1_wd;
  logic [11:0]     s1_h;
  tag_t            s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
    s1_den       <= den_c[11:0];
    s1_wd        <= perp_dist;
    s1_h         <= screen_height;
    s1_tag.ok    <= ok_c;
    s1_tag.dx    <= dx_c;
    s1_tag.dy    <= dy_c;
    s1_tag.px    <= player_x;
    s1_tag.py    <= player_y;
    s1_tag.faddr <= AddrW'(row) * AddrW'(screen_width) + AddrW'(column);
    s1_tag.caddr <= AddrW'(crow_c * AddrW'(screen_width)) + AddrW'(column);
  end

  // stage 2: divisor product
  logic            s2_vld;
  logic [DivW-1:0] s2_d;
  logic [DivW-1:0] s2_n;
  tag_t            s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_d   <= s1_den * s1_wd;
    s2_n   <= {16'b0, s1_h, 8'b0};
    s2_tag <= s1_tag;
  end

  // weight = H * 2^32 / divisor, saturating
  logic            dv_vld;
  logic [QuoW-1:0] dv_w;
  tag_t            dv_tag;

  fcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .in_num    (s2_n),
    .in_den    (s2_d),
    .in_tag    (s2_tag),
    .out_valid (dv_vld),
    .out_quo   (dv_w),
    .out_tag   (dv_tag)
  );

  // blend multiply: w * (base - player)
  localparam int unsigned PrW = QuoW + 1 + DeltaW;
  logic                  bl_vld;
  logic signed [PrW-1:0] bl_mx, bl_my;
  tag_t                  bl_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_vld <= 1'b0;
    end else begin
      bl_vld <= dv_vld;
    end
    bl_mx  <= $signed({1'b0, dv_w}) * dv_tag.dx;
    bl_my  <= $signed({1'b0, dv_w}) * dv_tag.dy;
    bl_tag <= dv_tag;
  end

  // add player term, clamp, texel lookup
  logic signed [PrW:0]  sx, sy;
  logic [CoordW-1:0]    fx_c, fy_c;
  logic [16+TsW-1:0]    tu_p, tv_p;

  assign sx = PrW'(bl_mx) + $signed({1'b0, PrW'({bl_tag.px, 16'b0})});
  assign sy = PrW'(bl_my) + $signed({1'b0, PrW'({bl_tag.py, 16'b0})});

  always_comb begin
    if (sx[PrW]) begin
      fx_c = '0;
    end else if (sx[PrW-1:16] > (PrW-16)'(CoordMax)) begin
      fx_c = CoordMax;
    end else begin
      fx_c = sx[CoordW+15:16];
    end
    if (sy[PrW]) begin
      fy_c = '0;
    end else if (sy[PrW-1:16] > (PrW-16)'(CoordMax)) begin
      fy_c = CoordMax;
    end else begin
      fy_c = sy[CoordW+15:16];
    end
  end

  assign tu_p = fx_c[15:0] * TexSide;
  assign tv_p = fy_c[15:0] * TexSide;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bl_vld;
    end
    valid_res  <= bl_tag.ok;
    floor_x    <= bl_tag.ok ? fx_c : '0;
    floor_y    <= bl_tag.ok ? fy_c : '0;
    tex_u      <= bl_tag.ok ? TexW'(tu_p[16+TsW-1:16]) : '0;
    tex_v      <= bl_tag.ok ? TexW'(tv_p[16+TsW-1:16]) : '0;
    floor_addr <= bl_tag.ok ? bl_tag.faddr : '0;
    ceil_addr  <= bl_tag.ok ? bl_tag.caddr : '0;
  end

endmodule

// ===== rtl/core/fcc_div.sv =====
// ----------------------------------------------------------------------------
// fcc_div
// Pipelined restoring divider: one quotient bit per stage, saturating to
// 24 bits. Numerator is num * 2^24 with num < 2^36.
// ----------------------------------------------------------------------------
module fcc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [fcc_pkg::DivW-1:0]   in_num,
  input  logic [fcc_pkg::DivW-1:0]   in_den,
  input  fcc_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output logic [fcc_pkg::QuoW-1:0]   out_quo,
  output fcc_pkg::tag_t              out_tag
);
  import fcc_pkg::*;

  logic              vld [QuoW+1];
  logic              sat [QuoW+1];
  logic [DivW:0]     rem [QuoW+1];
  logic [DivW-1:0]   den [QuoW+1];
  logic [QuoW-1:0]   quo [QuoW+1];
  tag_t              tag [QuoW+1];

  // entry stage: overflow check, quotient >= 2^24 iff num >= den
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    sat[0] <= (in_num >= in_den);
    rem[0] <= (in_num >= in_den) ? '0 : {1'b0, in_num};
    den[0] <= in_den;
    quo[0] <= '0;
    tag[0] <= in_tag;
  end

  // one quotient bit per stage; low numerator bits are zero
  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic [DivW:0] shl;
    logic          ge;
    assign shl = {rem[i][DivW-1:0], 1'b0};
    assign ge  = (shl >= {1'b0, den[i]});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      sat[i+1] <= sat[i];
      rem[i+1] <= ge ? (shl - {1'b0, den[i]}) : shl;
      den[i+1] <= den[i];
      quo[i+1] <= {quo[i][QuoW-2:0], ge};
      tag[i+1] <= tag[i];
    end
  end

  assign out_valid = vld[QuoW];
  assign out_quo   = sat[QuoW] ? {QuoW{1'b1}} : quo[QuoW];
  assign out_tag   = tag[QuoW];

endmodule

// ===== tb/fcc_checker.sv =====
// ----------------------------------------------------------------------------
// fcc_checker
// Watches the command and result channels of the floor/ceiling texel caster,
// predicts each result word in fixed point and compares it in order.
// ----------------------------------------------------------------------------
module fcc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic        y_side,
  input  logic        dir_positive,
  input  logic [7:0]  cell_x,
  input  logic [7:0]  cell_y,
  input  logic [15:0] wall_frac,
  input  logic [23:0] perp_dist,
  input  logic signed [17:0] half_step_x,
  input  logic signed [17:0] half_step_y,
  input  logic [23:0] player_x,
  input  logic [23:0] player_y,
  input  logic [10:0] row,
  input  logic [10:0] column,
  input  logic        done,
  input  logic        valid_res,
  input  logic [23:0] floor_x,
  input  logic [23:0] floor_y,
  input  logic [5:0]  tex_u,
  input  logic [5:0]  tex_v,
  input  logic [21:0] floor_addr,
  input  logic [21:0] ceil_addr,
  output int          errors,
  output int          pending,
  output int          n_words,
  output int          n_valid
);

  typedef struct packed {
    logic        ok;
    logic [23:0] fx;
    logic [23:0] fy;
    logic [5:0]  tu;
    logic [5:0]  tv;
    logic [21:0] fa;
    logic [21:0] ca;
  } pixel_t;

  localparam logic [2:0] AddrHeight = 3'd0;
  localparam logic [2:0] AddrWidth  = 3'd4;

  pixel_t     pixel_q[$];
  logic [11:0] scr_h, scr_w;

  // Q8.16 blend with clamp to [0, 0xFFFFFF]
  function automatic logic [23:0] mix(longint w, longint base, longint pl);
    longint s;
    s = w * base + (65536 - w) * pl;
    if (s < 0) return 24'd0;
    s = s >>> 16;
    return (s > 64'hFFFFFF) ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic pixel_t cast_pixel();
    pixel_t p;
    longint den, bx, by, w, hgt, wid, rr;
    logic [127:0] num, q;
    p = '0;
    hgt = scr_h; wid = scr_w; rr = row;
    den = 2 * rr - hgt;
    if (den <= 0 || perp_dist == 0) return p;
    if (!y_side) begin
      bx = (longint'(cell_x) << 16) + (dir_positive ? 0 : 65536);
      by = (longint'(cell_y) << 16) + wall_frac;
    end else begin
      bx = (longint'(cell_x) << 16) + wall_frac;
      by = (longint'(cell_y) << 16) + (dir_positive ? 0 : 65536);
    end
    num = 128'(hgt) << 32;
    q = num / (128'(den) * 128'(perp_dist));
    w = (q > 128'hFFFFFF) ? 64'hFFFFFF : longint'(q[63:0]);
    p.ok = 1'b1;
    p.fx = mix(w, bx + longint'(half_step_x), player_x);
    p.fy = mix(w, by + longint'(half_step_y), player_y);
    p.tu = p.fx[15:10];
    p.tv = p.fy[15:10];
    p.fa = 22'(rr * wid + column);
    p.ca = 22'((hgt - rr - 1) * wid + column);
    return p;
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    if (rst) begin
      scr_h <= 12'd600;
      scr_w <= 12'd800;
      errors <= 0;
      n_words <= 0;
      n_valid <= 0;
      pixel_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrHeight) scr_h <= pwdata[11:0];
        else if (paddr == AddrWidth) scr_w <= pwdata[11:0];
      end
      // command word accepted
      if (start && !busy) pixel_q.push_back(cast_pixel());
      // result word
      if (done) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result word", $time);
          errors <= errors + 1;
        end else begin
          pixel_t e, a;
          e = pixel_q.pop_front();
          a = {valid_res, floor_x, floor_y, tex_u, tex_v, floor_addr, ceil_addr};
          n_words <= n_words + 1;
          n_valid <= n_valid + e.ok;
          if (a != e) begin
            $display("%0t: mismatch exp ok=%0d fx=%h fy=%h u=%0d v=%0d fa=%h ca=%h",
                     $time, e.ok, e.fx, e.fy, e.tu, e.tv, e.fa, e.ca);
            $display("%0t:          act ok=%0d fx=%h fy=%h u=%0d v=%0d fa=%h ca=%h",
                     $time, a.ok, a.fx, a.fy, a.tu, a.tv, a.fa, a.ca);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the floor/ceiling texel caster with directed and random command
// words under several screen sizes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import fcc_pkg::*;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, done;
  logic y_side, dir_positive;
  logic [7:0] cell_x, cell_y;
  logic [15:0] wall_frac;
  logic [23:0] perp_dist, player_x, player_y;
  logic signed [17:0] half_step_x, half_step_y;
  logic [10:0] row, column;
  logic valid_res;
  logic [23:0] floor_x, floor_y;
  logic [5:0] tex_u, tex_v;
  logic [21:0] floor_addr, ceil_addr;
  int errors, pending, n_words, n_valid;
  int idle_pct;

  localparam logic [PaddrW-1:0] AddrHeight = PaddrW'(4 * RegHeight);
  localparam logic [PaddrW-1:0] AddrWidth  = PaddrW'(4 * RegWidth);
  localparam int Latency = 29;

  floor_ceiling_texel_caster u_top (.*);

  fcc_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic reg_write(input logic [PaddrW-1:0] a, input logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // set both screen registers once the pipe has drained
  task automatic set_screen(input logic [11:0] h, input logic [11:0] w);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
    reg_write(AddrHeight, {20'd0, h});
    reg_write(AddrWidth, {20'd0, w});
  endtask

  // send one word, optionally with random fields, with random sender gaps
  task automatic send_word(input logic [10:0] r, input logic [23:0] wd, input bit rnd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    row <= r; perp_dist <= wd;
    if (rnd) begin
      y_side <= 1'($urandom); dir_positive <= 1'($urandom);
      cell_x <= 8'($urandom); cell_y <= 8'($urandom); wall_frac <= 16'($urandom);
      half_step_x <= 18'(int'($urandom_range(131072)) - 65536);
      half_step_y <= 18'(int'($urandom_range(131072)) - 65536);
      player_x <= 24'($urandom); player_y <= 24'($urandom);
      column <= 11'($urandom);
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_block(input int n, input logic [11:0] h);
    logic [10:0] r;
    logic [23:0] wd;
    for (int i = 0; i < n; i++) begin
      r = 11'($urandom);
      if ($urandom_range(9) < 8 && h < 4096) r = 11'(($urandom_range(2047 - h/2) + h/2 + 1));
      case ($urandom_range(3))
        0: wd = 24'($urandom_range(255) + 1);
        1: wd = 24'($urandom_range(65535 * 4) + 1);
        2: wd = 24'($urandom);
        default: wd = ($urandom_range(19) == 0) ? 24'd0 : 24'($urandom_range(4000000));
      endcase
      send_word(r, wd, 1'b1);
    end
    start <= 1'b0;
  endtask

  initial begin
    int cyc;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; y_side = 0; dir_positive = 0; cell_x = 0; cell_y = 0;
    wall_frac = 0; perp_dist = 0; half_step_x = 0; half_step_y = 0;
    player_x = 0; player_y = 0; row = 0; column = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes at reset screen size
    for (int k = 0; k < 16; k++) begin
      y_side <= k[0]; dir_positive <= k[1];
      cell_x <= k[2] ? 8'hFF : 8'h00; cell_y <= k[3] ? 8'h00 : 8'hFF;
      wall_frac <= k[2] ? 16'hFFFF : 16'h0000;
      half_step_x <= k[3] ? 18'sd65536 : -18'sd65536;
      half_step_y <= k[1] ? -18'sd65536 : 18'sd65536;
      player_x <= k[0] ? 24'hFFFFFF : 24'h0; player_y <= k[2] ? 24'h0 : 24'hFFFFFF;
      column <= k[1] ? 11'h7FF : 11'h0;
      case (k[3:2])
        0: send_word(11'd301, 24'd1, 1'b0);        // weight saturates
        1: send_word(11'd2047, 24'hFFFFFF, 1'b0);  // tiny weight
        2: send_word(11'd300, 24'd65536, 1'b0);    // on the horizon: invalid
        default: send_word(11'd400, 24'd0, 1'b0);  // zero distance: invalid
      endcase
    end
    send_word(11'd0, 24'd65536, 1'b0);
    start <= 1'b0;
    // register extremes, including out-of-range values
    set_screen(12'd0, 12'd0);
    random_block(4, 12'd0);
    set_screen(12'hFFF, 12'hFFF);
    random_block(4, 12'hFFF);

    // random phases over several screen sizes and idling profiles
    idle_pct = 37;
    set_screen(12'd2, 12'd1);
    random_block(50, 12'd2);
    set_screen(12'd2048, 12'd2048);
    random_block(50, 12'd2048);
    set_screen(12'd600, 12'd800);
    random_block(50, 12'd600);
    idle_pct = 82;
    set_screen(12'($urandom_range(2046) + 2), 12'($urandom_range(2047) + 1));
    random_block(100, 12'd1024);
    idle_pct = 0;
    set_screen(12'd480, 12'd640);
    random_block(100, 12'd480);
    set_screen(12'd1080, 12'd1920);
    random_block(75, 12'd1080);

    // drain
    cyc = 0;
    while (pending != 0 && cyc < 10000) begin
      @(posedge clk);
      cyc++;
    end
    repeat (Latency + 5) @(posedge clk);
    $display("Covered %0d result words (%0d valid) over eight screen settings.",
             n_words, n_valid);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== floor_ceiling_texel_caster.f =====
rtl/core/fcc_pkg.sv
rtl/core/fcc_div.sv
rtl/core/floor_ceiling_texel_caster.sv
tb/fcc_checker.sv
tb/testbench.sv
